### design/qspa_pkg.sv
package qspa_pkg;

	localparam int QW      = 16;
	localparam int SCW     = 16;
	localparam int POSW    = 32;
	localparam int MW      = 32;
	localparam int PRODW   = 32;
	localparam int NORMW   = 33;
	localparam int NUMW    = 34;
	localparam int WIDEW   = 36;
	localparam int SPW     = 50;
	localparam int MAGW    = 48;
	localparam int RND_SH  = 9;
	localparam int DVDW    = MAGW + RND_SH + 1;
	localparam int QUOW    = 25;
	localparam int REMW    = NORMW + 1;
	localparam int NELEM   = 9;
	localparam int NAXIS   = 3;

	localparam logic signed [SCW-1:0] SCALE_ONE = 16'sd256;

	typedef logic signed [NUMW-1:0] num_t;
	typedef logic signed [SCW-1:0]  scale_t;
	typedef logic signed [POSW-1:0] pos_t;

	typedef struct packed {
		logic [NELEM-1:0] neg;
		pos_t             px;
		pos_t             py;
		pos_t             pz;
	} side_t;

endpackage

### design/qspa_in_if.sv
interface qspa_in_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   quat_w;
	logic signed [15:0]   quat_x;
	logic signed [15:0]   quat_y;
	logic signed [15:0]   quat_z;
	logic signed [15:0]   scale_x;
	logic signed [15:0]   scale_y;
	logic signed [15:0]   scale_z;
	logic signed [31:0]   pos_x;
	logic signed [31:0]   pos_y;
	logic signed [31:0]   pos_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
		pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
		pos_x, pos_y, pos_z, output ready);
endinterface

### design/qspa_out_if.sv
interface qspa_out_if;
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   m00;
	logic signed [31:0]   m01;
	logic signed [31:0]   m02;
	logic signed [31:0]   m10;
	logic signed [31:0]   m11;
	logic signed [31:0]   m12;
	logic signed [31:0]   m20;
	logic signed [31:0]   m21;
	logic signed [31:0]   m22;
	logic signed [31:0]   trans_x;
	logic signed [31:0]   trans_y;
	logic signed [31:0]   trans_z;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		trans_x, trans_y, trans_z, input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		trans_x, trans_y, trans_z, output ready);
endinterface

### design/qspa_div.sv
module qspa_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [qspa_pkg::MAGW-1:0]       mag,
	input  logic [qspa_pkg::NORMW-1:0]      norm,
	output logic [qspa_pkg::QUOW-1:0]       quo
);

	logic [qspa_pkg::DVDW-1:0] dvd;
	logic [qspa_pkg::REMW-1:0] rem_s [0:qspa_pkg::QUOW];
	logic [qspa_pkg::QUOW-1:0] bits_s [0:qspa_pkg::QUOW];
	logic [qspa_pkg::REMW-1:0] den_s [0:qspa_pkg::QUOW];

	// round half away: (mag * 512 + n) / (2n)
	assign dvd = {mag, {qspa_pkg::RND_SH{1'b0}}, 1'b0} >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= qspa_pkg::REMW'((dvd + qspa_pkg::DVDW'(norm)) >> qspa_pkg::QUOW);
			bits_s[0] <= qspa_pkg::QUOW'(dvd + qspa_pkg::DVDW'(norm));
			den_s[0]  <= {norm, 1'b0};
		end
	end

	for (genvar k = 0; k < qspa_pkg::QUOW; k++) begin : g_step
		logic [qspa_pkg::REMW:0] trial;
		logic                    take;

		assign trial = {rem_s[k], bits_s[k][qspa_pkg::QUOW-1]};
		assign take  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? qspa_pkg::REMW'(trial - {1'b0, den_s[k]})
					: trial[qspa_pkg::REMW-1:0];
				bits_s[k+1] <= {bits_s[k][qspa_pkg::QUOW-2:0], take};
				den_s[k+1]  <= den_s[k];
			end
		end
	end

	assign quo = bits_s[qspa_pkg::QUOW];

endmodule

### design/quat_scale_pos_to_affine.sv
// Turns a quaternion (any length), a per-axis Q8.8 scale and a Q16.16 position into a 3x4
// affine transform: row i of the rotation of q is multiplied by scale i, rounded to nearest
// (ties away from zero) in Q16.16, and the position passes through as the fourth column.
// A zero quaternion gives the identity rotation; a zero scale component counts as one.
// One item is taken every clock cycle while the output is not stalled; each item passes through
// the capture, product, sum and scaling stages, then nine pipelined restoring dividers that give one
// quotient bit per stage, then the output register. The whole pipeline holds while a result
// waits at the output, so the input is ready whenever the output is empty or being taken.
module quat_scale_pos_to_affine (
	input  logic        clk,
	input  logic        arst_n,
	qspa_in_if.sink     in_ch,
	qspa_out_if.source  out_ch
);

	logic adv;

	logic signed [qspa_pkg::QW-1:0] w_s1, x_s1, y_s1, z_s1;
	qspa_pkg::scale_t               sc_s1 [qspa_pkg::NAXIS];
	qspa_pkg::pos_t                 px_s1, py_s1, pz_s1;
	logic                           vld_s1;

	logic signed [qspa_pkg::PRODW-1:0] ww_s2, xx_s2, yy_s2, zz_s2, xy_s2, wz_s2, xz_s2, wy_s2,
		yz_s2, wx_s2;
	qspa_pkg::scale_t               sc_s2 [qspa_pkg::NAXIS];
	qspa_pkg::pos_t                 px_s2, py_s2, pz_s2;
	logic                           vld_s2;

	logic [qspa_pkg::NORMW-1:0]     n_s3;
	qspa_pkg::num_t                 num_s3 [qspa_pkg::NELEM];
	qspa_pkg::scale_t               sc_s3 [qspa_pkg::NAXIS];
	qspa_pkg::pos_t                 px_s3, py_s3, pz_s3;
	logic                           vld_s3;

	logic [qspa_pkg::MAGW-1:0]      mag_s4 [qspa_pkg::NELEM];
	logic [qspa_pkg::NORMW-1:0]     n_s4;
	qspa_pkg::side_t                side_s4;
	logic                           vld_s4;

	qspa_pkg::side_t                side_d [0:qspa_pkg::QUOW];
	logic [qspa_pkg::QUOW:0]        vld_d;
	logic [qspa_pkg::QUOW-1:0]      quo [qspa_pkg::NELEM];

	logic signed [qspa_pkg::MW-1:0] m_q [qspa_pkg::NELEM];
	qspa_pkg::pos_t                 tx_q, ty_q, tz_q;
	logic                           out_vld_q;

	assign adv         = !out_vld_q || out_ch.ready;
	assign in_ch.ready = adv;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_d     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_ch.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_d     <= {vld_d[qspa_pkg::QUOW-1:0], vld_s4};
			out_vld_q <= vld_d[qspa_pkg::QUOW];
		end
	end

	// stage 1: capture, zero scale becomes one
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1     <= in_ch.quat_w;
			x_s1     <= in_ch.quat_x;
			y_s1     <= in_ch.quat_y;
			z_s1     <= in_ch.quat_z;
			sc_s1[0] <= (in_ch.scale_x == '0) ? qspa_pkg::SCALE_ONE : in_ch.scale_x;
			sc_s1[1] <= (in_ch.scale_y == '0) ? qspa_pkg::SCALE_ONE : in_ch.scale_y;
			sc_s1[2] <= (in_ch.scale_z == '0) ? qspa_pkg::SCALE_ONE : in_ch.scale_z;
			px_s1    <= in_ch.pos_x;
			py_s1    <= in_ch.pos_y;
			pz_s1    <= in_ch.pos_z;
		end
	end

	// stage 2: pairwise products
	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s2 <= w_s1 * w_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			wz_s2 <= w_s1 * z_s1;
			xz_s2 <= x_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			yz_s2 <= y_s1 * z_s1;
			wx_s2 <= w_s1 * x_s1;
			sc_s2 <= sc_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
		end
	end

	// stage 3: norm and numerators
	logic signed [qspa_pkg::WIDEW-1:0] n_w;
	logic signed [qspa_pkg::WIDEW-1:0] nm [qspa_pkg::NELEM];

	always_comb begin
		n_w   = qspa_pkg::WIDEW'(ww_s2) + qspa_pkg::WIDEW'(xx_s2) + qspa_pkg::WIDEW'(yy_s2)
			+ qspa_pkg::WIDEW'(zz_s2);
		nm[0] = n_w - ((qspa_pkg::WIDEW'(yy_s2) + qspa_pkg::WIDEW'(zz_s2)) <<< 1);
		nm[1] = (qspa_pkg::WIDEW'(xy_s2) + qspa_pkg::WIDEW'(wz_s2)) <<< 1;
		nm[2] = (qspa_pkg::WIDEW'(xz_s2) - qspa_pkg::WIDEW'(wy_s2)) <<< 1;
		nm[3] = (qspa_pkg::WIDEW'(xy_s2) - qspa_pkg::WIDEW'(wz_s2)) <<< 1;
		nm[4] = n_w - ((qspa_pkg::WIDEW'(xx_s2) + qspa_pkg::WIDEW'(zz_s2)) <<< 1);
		nm[5] = (qspa_pkg::WIDEW'(yz_s2) + qspa_pkg::WIDEW'(wx_s2)) <<< 1;
		nm[6] = (qspa_pkg::WIDEW'(xz_s2) + qspa_pkg::WIDEW'(wy_s2)) <<< 1;
		nm[7] = (qspa_pkg::WIDEW'(yz_s2) - qspa_pkg::WIDEW'(wx_s2)) <<< 1;
		nm[8] = n_w - ((qspa_pkg::WIDEW'(xx_s2) + qspa_pkg::WIDEW'(yy_s2)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (n_w == '0) begin
				n_s3 <= qspa_pkg::NORMW'(1);
				for (int i = 0; i < qspa_pkg::NELEM; i++) begin
					num_s3[i] <= (i % 4 == 0) ? qspa_pkg::NUMW'(1) : '0;
				end
			end else begin
				n_s3 <= n_w[qspa_pkg::NORMW-1:0];
				for (int i = 0; i < qspa_pkg::NELEM; i++) begin
					num_s3[i] <= nm[i][qspa_pkg::NUMW-1:0];
				end
			end
			sc_s3 <= sc_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			pz_s3 <= pz_s2;
		end
	end

	// stage 4: scale each row, split sign and magnitude
	logic signed [qspa_pkg::SPW-1:0] sp [qspa_pkg::NELEM];

	always_comb begin
		for (int i = 0; i < qspa_pkg::NELEM; i++) begin
			sp[i] = qspa_pkg::SPW'(num_s3[i]) * qspa_pkg::SPW'(sc_s3[i / qspa_pkg::NAXIS]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < qspa_pkg::NELEM; i++) begin
				side_s4.neg[i] <= sp[i] < 0;
				mag_s4[i]      <= (sp[i] < 0) ? qspa_pkg::MAGW'(-sp[i]) : qspa_pkg::MAGW'(sp[i]);
			end
			n_s4       <= n_s3;
			side_s4.px <= px_s3;
			side_s4.py <= py_s3;
			side_s4.pz <= pz_s3;
		end
	end

	for (genvar e = 0; e < qspa_pkg::NELEM; e++) begin : g_lane
		qspa_div u_div (
			.clk  (clk),
			.en   (adv),
			.mag  (mag_s4[e]),
			.norm (n_s4),
			.quo  (quo[e])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_s4;
			for (int k = 1; k <= qspa_pkg::QUOW; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < qspa_pkg::NELEM; i++) begin
				m_q[i] <= side_d[qspa_pkg::QUOW].neg[i] ? -qspa_pkg::MW'(quo[i])
					: qspa_pkg::MW'(quo[i]);
			end
			tx_q <= side_d[qspa_pkg::QUOW].px;
			ty_q <= side_d[qspa_pkg::QUOW].py;
			tz_q <= side_d[qspa_pkg::QUOW].pz;
		end
	end

	assign out_ch.valid   = out_vld_q;
	assign out_ch.m00     = m_q[0];
	assign out_ch.m01     = m_q[1];
	assign out_ch.m02     = m_q[2];
	assign out_ch.m10     = m_q[3];
	assign out_ch.m11     = m_q[4];
	assign out_ch.m12     = m_q[5];
	assign out_ch.m20     = m_q[6];
	assign out_ch.m21     = m_q[7];
	assign out_ch.m22     = m_q[8];
	assign out_ch.trans_x = tx_q;
	assign out_ch.trans_y = ty_q;
	assign out_ch.trans_z = tz_q;

endmodule

### design/qspa_check.sv
module qspa_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] m00,
	input logic signed [31:0] m11,
	input logic signed [31:0] trans_x
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(trans_x))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_rng00: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m00 <= 32'sd8388608 && m00 >= -32'sd8388608)
		else $error("m00 beyond scaled unit range");

	a_rng11: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m11 <= 32'sd8388608 && m11 >= -32'sd8388608)
		else $error("m11 beyond scaled unit range");

endmodule

bind quat_scale_pos_to_affine qspa_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.m00       (out_ch.m00),
	.m11       (out_ch.m11),
	.trans_x   (out_ch.trans_x)
);
